### rtl/core/z80alu_pkg.sv
// z80alu_pkg: operation codes, flag bit positions and the request/response
// structs shared by the Z80-style ALU core and its top level.
// No dependencies.
`default_nettype none

package z80alu_pkg;

	// operation codes carried in the input tuser field
	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_ADC   = 5'd1,
		OP_SUB   = 5'd2,
		OP_SBC   = 5'd3,
		OP_AND   = 5'd4,
		OP_XOR   = 5'd5,
		OP_OR    = 5'd6,
		OP_CP    = 5'd7,
		OP_INC   = 5'd8,
		OP_DEC   = 5'd9,
		OP_RLCA  = 5'd10,
		OP_RRCA  = 5'd11,
		OP_RLA   = 5'd12,
		OP_RRA   = 5'd13,
		OP_CPL   = 5'd14,
		OP_SCF   = 5'd15,
		OP_CCF   = 5'd16,
		OP_ADD16 = 5'd17
	} alu_op_t;

	// flag byte layout S Z Y H X P N C
	localparam int unsigned FL_S = 7;
	localparam int unsigned FL_Z = 6;
	localparam int unsigned FL_Y = 5;
	localparam int unsigned FL_H = 4;
	localparam int unsigned FL_X = 3;
	localparam int unsigned FL_P = 2;
	localparam int unsigned FL_N = 1;
	localparam int unsigned FL_C = 0;

	typedef struct packed {
		logic [4:0]  op;
		logic [15:0] operand_a;
		logic [15:0] operand_b;
		logic [7:0]  flags;
	} alu_req_t;

	typedef struct packed {
		logic [15:0] result;
		logic [7:0]  flags;
	} alu_rsp_t;

endpackage

`default_nettype wire

### rtl/core/z80alu_core.sv
// z80alu_core: combinational Z80-style ALU, one operation from request to
// response (result word and new flag byte). Depends on z80alu_pkg.
`default_nettype none

module z80alu_core (
	input  wire z80alu_pkg::alu_req_t req,
	output z80alu_pkg::alu_rsp_t rsp
);
	import z80alu_pkg::*;

	alu_op_t     op;
	logic [7:0]  a8;
	logic [7:0]  fi;
	logic        cin;
	logic        is_sub;
	logic        use_carry;
	logic        is_incdec;
	logic [7:0]  addend;
	logic        carry_in;
	logic [8:0]  sum9;
	logic [7:0]  ar;
	logic [7:0]  cx;
	logic        half;
	logic        carry;
	logic [7:0]  arith_fl;
	logic [7:0]  lr;
	logic [7:0]  logic_fl;
	logic [16:0] sum17;
	logic [7:0]  r8;
	logic [7:0]  fo;

	assign op  = alu_op_t'(req.op);
	assign a8  = req.operand_a[7:0];
	assign fi  = req.flags;
	assign cin = fi[FL_C];

	// shared 8-bit adder: subtraction adds the inverted operand and the inverted borrow
	assign is_sub    = (op == OP_SUB) || (op == OP_SBC) || (op == OP_CP) || (op == OP_DEC);
	assign use_carry = (op == OP_ADC) || (op == OP_SBC);
	assign is_incdec = (op == OP_INC) || (op == OP_DEC);

	always_comb begin
		logic [7:0] bx;
		bx       = is_incdec ? 8'h01 : req.operand_b[7:0];
		addend   = is_sub ? ~bx : bx;
		carry_in = is_sub ? ~(use_carry & cin) : (use_carry & cin);
	end

	assign sum9  = {1'b0, a8} + {1'b0, addend} + {8'h00, carry_in};
	assign ar    = sum9[7:0];
	assign cx    = ar ^ a8 ^ addend;
	assign half  = cx[4] ^ is_sub;
	assign carry = is_sub ? ~sum9[8] : sum9[8];

	// arithmetic flags keep old bits 3 and 5; inc/dec keep old carry
	assign arith_fl = {ar[7], (ar == 8'h00), fi[FL_Y], half, fi[FL_X],
		cx[7] ^ sum9[8], is_sub, is_incdec ? cin : carry};

	// logic unit with sign/zero/parity flags from the result
	always_comb begin
		case (op)
			OP_AND:  lr = a8 & req.operand_b[7:0];
			OP_XOR:  lr = a8 ^ req.operand_b[7:0];
			default: lr = a8 | req.operand_b[7:0];
		endcase
	end

	assign logic_fl = {lr[7], (lr == 8'h00), lr[5], (op == OP_AND), lr[3], ~(^lr), 2'b00};

	// 16-bit add
	assign sum17 = {1'b0, req.operand_a} + {1'b0, req.operand_b};

	// operation select
	always_comb begin
		r8 = a8;
		fo = fi;
		unique case (op)
			OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_INC, OP_DEC: begin
				r8 = ar;
				fo = arith_fl;
			end
			OP_CP: begin
				fo = arith_fl;
			end
			OP_AND, OP_XOR, OP_OR: begin
				r8 = lr;
				fo = logic_fl;
			end
			OP_RLCA: begin
				r8 = {a8[6:0], a8[7]};
				fo = {fi[7:5], 1'b0, fi[3:2], 1'b0, a8[7]};
			end
			OP_RRCA: begin
				r8 = {a8[0], a8[7:1]};
				fo = {fi[7:5], 1'b0, fi[3:2], 1'b0, a8[0]};
			end
			OP_RLA: begin
				r8 = {a8[6:0], cin};
				fo = {fi[7:5], 1'b0, fi[3:2], 1'b0, a8[7]};
			end
			OP_RRA: begin
				r8 = {cin, a8[7:1]};
				fo = {fi[7:5], 1'b0, fi[3:2], 1'b0, a8[0]};
			end
			OP_CPL: begin
				r8 = ~a8;
				fo = fi | 8'h12;
			end
			OP_SCF: begin
				fo = {fi[7:5], 1'b0, fi[3:2], 1'b0, 1'b1};
			end
			OP_CCF: begin
				fo = {fi[7:5], cin, fi[3:2], 1'b0, ~cin};
			end
			OP_ADD16: begin
				fo = {fi[7:2], 1'b0, sum17[16]};
			end
			default: begin
				r8 = a8;
				fo = fi;
			end
		endcase
	end

	assign rsp.result = (op == OP_ADD16) ? sum17[15:0] : {8'h00, r8};
	assign rsp.flags  = fo;

endmodule

`default_nettype wire

### rtl/core/z80_alu_with_flags.sv
// z80_alu_with_flags: top level, input request register, ALU core and
// response register with stream handshakes. Depends on z80alu_pkg, z80alu_core.
//
// Usage:
//   Input channel s_*: one request per s_tvalid & s_tready edge. s_tuser
//   carries the operation code, s_tdata the two operands and the current
//   flag byte. Output channel m_*: one response per request, in order,
//   with the result word and the new flag byte in m_tdata.
//   Path: an accepted request passes through the input register, then the
//   response register, before it is presented on m_*.
//   Throughput: one request per cycle, sustained while m_tready stays high;
//   the ALU is a single combinational pass between the two registers.
//   Stall: when m_tready is low the response register holds; the input
//   register still takes one more request, after which s_tready drops
//   until the output drains. s_tready follows m_tready in the same cycle.
//   Reset: arst_n clears both valid flags at once; no request is held and
//   the block is ready right after reset.
`default_nettype none

module z80_alu_with_flags (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,  // operand_a[15:0], operand_b[31:16], flags_in[39:32]
	input  wire  [7:0]  s_tuser,  // opcode[4:0], zero fill [7:5]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata   // result[15:0], flags_out[23:16]
);
	import z80alu_pkg::*;

	alu_req_t req_s1;
	logic     valid_s1;
	alu_rsp_t rsp_core;
	alu_rsp_t rsp_s2;
	logic     valid_s2;
	logic     adv_s2;
	logic     load_s1;

	// flow control: each stage loads when it is empty or drains this cycle
	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;
	assign load_s1  = s_tvalid && s_tready;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			req_s1.op        <= s_tuser[4:0];
			req_s1.operand_a <= s_tdata[15:0];
			req_s1.operand_b <= s_tdata[31:16];
			req_s1.flags     <= s_tdata[39:32];
		end
	end

	z80alu_core u_core (
		.req (req_s1),
		.rsp (rsp_core)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			rsp_s2 <= rsp_core;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {rsp_s2.flags, rsp_s2.result};

`ifndef SYNTHESIS
	// an accepted request is held in the input register next cycle
	a_req_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted request not captured");

	// a full input register with an empty output moves forward
	a_req_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !m_tvalid |=> m_tvalid)
		else $error("request did not advance to the response register");

	// both stages full and output stalled: no new request may enter
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_tvalid && !m_tready |-> !s_tready)
		else $error("request accepted while pipeline full");
`endif

endmodule

`default_nettype wire
